// ===== design/uvs_pkg.sv =====
// Shared constants, the quarter-wave sine table builder and a rounding helper.
package uvs_pkg;

  localparam int MAX_SEG      = 256;
  localparam int SEG_W        = 9;
  localparam int SINE_ENTRIES = 1024;
  localparam int ADDR_W       = 10;
  localparam int PHASE_W      = 12;
  localparam int SINE_W       = 15;
  localparam int Q_W          = 17;
  localparam int DIV_STEPS    = Q_W;
  localparam int ONE_Q14      = 16384;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] SINE_DEN = 64'(2 * SINE_ENTRIES);

  // Taylor term divisors (2n)(2n+1) for n = 1..12, entry 0 holds n = 1.
  localparam logic [11:0][9:0] TAYLOR_DEN = {
    10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
    10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
  };

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd2;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

  // Quarter-wave sine in Q1.14 from a Taylor series evaluated in Q30.
  function automatic sine_rom_t build_sine();
    sine_rom_t   t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x    = (64'(k) * PI_Q30 + SINE_DEN / 64'd2) / SINE_DEN;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[n-1]);
        if ((n % 2) == 1) neg = neg + term;
        else pos = pos + term;
      end
      v = (pos > neg) ? pos - neg : 64'd0;
      v = (v + 64'd32768) >> 16;
      if (v > 64'(ONE_Q14)) v = 64'(ONE_Q14);
      t[k] = SINE_W'(v);
    end
    return t;
  endfunction

  // Shift right with rounding of halves away from zero.
  function automatic logic signed [47:0] round_sh(input logic signed [47:0] v,
                                                  input int sh);
    logic [47:0] mag;
    mag = v[47] ? 48'(-v) : 48'(v);
    mag = (mag + (48'd1 << (sh - 1))) >> sh;
    return v[47] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== design/uvs_div.sv =====
// Pipelined restoring divider: (num * 2^16) / den, one quotient bit per stage.
module uvs_div (
  input  logic                       clk,
  input  logic [uvs_pkg::SEG_W-1:0]  num,
  input  logic [uvs_pkg::SEG_W-1:0]  den,
  output logic [uvs_pkg::Q_W-1:0]    quo,
  output logic [uvs_pkg::SEG_W-1:0]  rem
);
  import uvs_pkg::*;

  logic [SEG_W-1:0] p_q [DIV_STEPS];
  logic [SEG_W-1:0] d_q [DIV_STEPS];
  logic [Q_W-1:0]   q_q [DIV_STEPS];
  logic [SEG_W-1:0] p_next [DIV_STEPS];
  logic [SEG_W-1:0] d_next [DIV_STEPS];
  logic [Q_W-1:0]   q_next [DIV_STEPS];

  always_comb begin
    logic [SEG_W:0] t;
    logic           ge;
    ge        = num >= den;
    p_next[0] = ge ? SEG_W'(num - den) : num;
    q_next[0] = Q_W'(ge) << (Q_W - 1);
    d_next[0] = den;
    for (int i = 1; i < DIV_STEPS; i++) begin
      t         = {p_q[i-1], 1'b0};
      ge        = t >= {1'b0, d_q[i-1]};
      p_next[i] = ge ? SEG_W'(t - {1'b0, d_q[i-1]}) : SEG_W'(t);
      q_next[i] = q_q[i-1] | (Q_W'(ge) << (Q_W - 1 - i));
      d_next[i] = d_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      p_q[i] <= p_next[i];
      d_q[i] <= d_next[i];
      q_q[i] <= q_next[i];
    end
  end

  assign quo = q_q[DIV_STEPS-1];
  assign rem = p_q[DIV_STEPS-1];

endmodule

// ===== design/uvs_sine_rom.sv =====
// Quarter-wave sine ROM with two registered read ports.
module uvs_sine_rom (
  input  logic                        clk,
  input  logic [uvs_pkg::ADDR_W-1:0]  addr_a,
  input  logic [uvs_pkg::ADDR_W-1:0]  addr_b,
  output logic [uvs_pkg::SINE_W-1:0]  data_a,
  output logic [uvs_pkg::SINE_W-1:0]  data_b
);
  import uvs_pkg::*;

  localparam sine_rom_t ROM = build_sine();

  always_ff @(posedge clk) begin
    data_a <= ROM[addr_a];
    data_b <= ROM[addr_b];
  end

endmodule

// ===== design/uv_sphere_vertex_generator_top.sv =====
// Top level of the UV-sphere vertex generator.
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  -------------------------
//  input     ring, column                              start high, busy low
//  config    cfg_we, cfg_index, cfg_data               cfg_we high
//  result    pos_*, normal_*, tangent_*, tex_*, err    done high for one cycle
//
// One word enters every cycle while busy is low; the pipeline depth is set
// by the 17-stage divider that yields the angle phases and the texture
// coordinates, followed by phase decode, ROM read and three multiply and
// rounding stages. Reset is synchronous: it clears the valid bits and
// restores radius 1.0 and 32 slices and stacks; busy is high only in the cycle
// after a reset cycle. The receiver cannot stall, so the pipeline never stops.
module uv_sphere_vertex_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [uvs_pkg::SEG_W-1:0]      ring,
  input  logic [uvs_pkg::SEG_W-1:0]      column,
  input  logic                           cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]      cfg_data,
  output logic                           done,
  output logic signed [16:0]             pos_x,
  output logic signed [16:0]             pos_y,
  output logic signed [16:0]             pos_z,
  output logic signed [15:0]             normal_x,
  output logic signed [15:0]             normal_y,
  output logic signed [15:0]             normal_z,
  output logic signed [16:0]             tangent_x,
  output logic signed [16:0]             tangent_z,
  output logic [16:0]                    tex_u,
  output logic [16:0]                    tex_v,
  output logic                           range_error
);
  import uvs_pkg::*;

  // Sideband flags travel alongside each word from the input register on.
  typedef struct packed {
    logic valid;
    logic err;
    logic top;
    logic bot;
  } side_t;

  localparam int SIDE_DEPTH = 22;
  localparam int TEX_DEPTH  = 4;

  logic [15:0]      radius;
  logic [SEG_W-1:0] slices;
  logic [SEG_W-1:0] stacks;
  logic [SEG_W-1:0] sl;
  logic [SEG_W-1:0] st;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      slices <= SEG_W'(32);
      stacks <= SEG_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: radius <= cfg_data;
        CFG_SLICES: slices <= cfg_data[SEG_W-1:0];
        CFG_STACKS: stacks <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective segment counts are the registers clamped to the legal range.
  always_comb begin
    if (slices < SEG_W'(3)) sl = SEG_W'(3);
    else if (slices > SEG_W'(MAX_SEG)) sl = SEG_W'(MAX_SEG);
    else sl = slices;
    if (stacks < SEG_W'(2)) st = SEG_W'(2);
    else if (stacks > SEG_W'(MAX_SEG)) st = SEG_W'(MAX_SEG);
    else st = stacks;
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Input register: range check and pole detection.
  side_t            side [SIDE_DEPTH];
  logic [SEG_W-1:0] ring_q;
  logic [SEG_W-1:0] col_q;

  always_ff @(posedge clk) begin
    ring_q <= ring;
    col_q  <= column;
    if (rst) begin
      for (int i = 0; i < SIDE_DEPTH; i++) side[i].valid <= 1'b0;
    end else begin
      side[0].valid <= start && !busy;
      for (int i = 1; i < SIDE_DEPTH; i++) side[i].valid <= side[i-1].valid;
    end
    side[0].err <= (ring > st) || (column > sl);
    side[0].top <= ring == '0;
    side[0].bot <= ring == st;
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side[i].err <= side[i-1].err;
      side[i].top <= side[i-1].top;
      side[i].bot <= side[i-1].bot;
    end
  end

  // Both index fractions scaled by 2^16, with remainders for rounding.
  logic [Q_W-1:0]   qc;
  logic [Q_W-1:0]   qr;
  logic [SEG_W-1:0] remc;
  logic [SEG_W-1:0] remr;

  uvs_div u_div_col (.clk(clk), .num(col_q), .den(sl), .quo(qc), .rem(remc));
  uvs_div u_div_ring (.clk(clk), .num(ring_q), .den(st), .quo(qr), .rem(remr));

  // Phase decode. Theta steps are 2^16/4096 of a turn fraction and phi steps
  // 2^16/2048 of a half turn, so the phases are rounded shifts of the quotients.
  logic [PHASE_W-1:0] ph_th;
  logic [PHASE_W-1:0] ph_ph;
  logic [PHASE_W-1:0] ph_in [4];
  logic [ADDR_W:0]    idx [4];
  logic [ADDR_W-1:0]  addr_q [4];
  logic               full_q [4];
  logic               neg_q [4];
  logic [16:0]        tex_u_d [TEX_DEPTH];
  logic [16:0]        tex_v_d [TEX_DEPTH];
  logic [Q_W:0]       sum_th;
  logic [Q_W:0]       sum_ph;

  always_comb begin
    sum_th   = {1'b0, qc} + (Q_W+1)'(8);
    sum_ph   = {1'b0, qr} + (Q_W+1)'(16);
    ph_th    = sum_th[PHASE_W+3:4];
    ph_ph    = sum_ph[PHASE_W+4:5];
    ph_in[0] = ph_ph;
    ph_in[1] = ph_ph + PHASE_W'(SINE_ENTRIES);
    ph_in[2] = ph_th;
    ph_in[3] = ph_th + PHASE_W'(SINE_ENTRIES);
    for (int i = 0; i < 4; i++) begin
      if (ph_in[i][ADDR_W])
        idx[i] = (ADDR_W+1)'(SINE_ENTRIES) - {1'b0, ph_in[i][ADDR_W-1:0]};
      else
        idx[i] = {1'b0, ph_in[i][ADDR_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      addr_q[i] <= idx[i][ADDR_W-1:0];
      full_q[i] <= idx[i][ADDR_W];
      neg_q[i]  <= ph_in[i][ADDR_W+1];
    end
    tex_u_d[0] <= qc + 17'({remc, 1'b0} >= {1'b0, sl});
    tex_v_d[0] <= qr + 17'({remr, 1'b0} >= {1'b0, st});
    for (int i = 1; i < TEX_DEPTH; i++) begin
      tex_u_d[i] <= tex_u_d[i-1];
      tex_v_d[i] <= tex_v_d[i-1];
    end
  end

  // Table read: index 0/1 are sin and cos of phi, 2/3 of theta.
  logic [SINE_W-1:0] rom_d [4];
  logic              full_r [4];
  logic              neg_r [4];

  uvs_sine_rom u_rom_phi (
    .clk(clk), .addr_a(addr_q[0]), .addr_b(addr_q[1]),
    .data_a(rom_d[0]), .data_b(rom_d[1])
  );
  uvs_sine_rom u_rom_theta (
    .clk(clk), .addr_a(addr_q[2]), .addr_b(addr_q[3]),
    .data_a(rom_d[2]), .data_b(rom_d[3])
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      full_r[i] <= full_q[i];
      neg_r[i]  <= neg_q[i];
    end
  end

  logic signed [15:0] trig [4];

  always_comb begin
    logic [15:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag     = full_r[i] ? 16'(ONE_Q14) : {1'b0, rom_d[i]};
      trig[i] = neg_r[i] ? -$signed(mag) : $signed(mag);
    end
  end

  // First products: sin(phi)cos(theta), sin(phi)sin(theta), R cos(phi).
  logic signed [31:0] spct;
  logic signed [31:0] spst;
  logic signed [32:0] rcp;
  logic signed [15:0] cp_q;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    spct <= trig[0] * trig[3];
    spst <= trig[0] * trig[2];
    rcp  <= rad_s * trig[1];
    cp_q <= trig[1];
  end

  // Second products and the Q1.14 normal.
  logic signed [47:0] rspct;
  logic signed [47:0] rspst;
  logic signed [15:0] nx_q;
  logic signed [15:0] ny_q;
  logic signed [15:0] nz_q;
  logic signed [16:0] py_q;

  always_ff @(posedge clk) begin
    rspct <= 48'(rad_s * spct);
    rspst <= 48'(rad_s * spst);
    nx_q  <= 16'(round_sh(48'(spct), 14));
    nz_q  <= 16'(round_sh(48'(spst), 14));
    ny_q  <= cp_q;
    py_q  <= 17'(round_sh(48'(rcp), 14));
  end

  // Output register: pole and error words override the computed vertex.
  logic signed [16:0] px_c;
  logic signed [16:0] pz_c;
  side_t              s_last;

  assign px_c   = 17'(round_sh(rspct, 28));
  assign pz_c   = 17'(round_sh(rspst, 28));
  assign s_last = side[SIDE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s_last.valid;
    pos_x       <= '0;
    pos_y       <= '0;
    pos_z       <= '0;
    normal_x    <= '0;
    normal_y    <= '0;
    normal_z    <= '0;
    tangent_x   <= '0;
    tangent_z   <= '0;
    tex_u       <= '0;
    tex_v       <= '0;
    range_error <= 1'b0;
    if (s_last.err) begin
      range_error <= 1'b1;
    end else if (s_last.top) begin
      pos_y     <= $signed({1'b0, radius});
      normal_y  <= 16'(ONE_Q14);
      tangent_x <= 17'sd256;
    end else if (s_last.bot) begin
      pos_y     <= -$signed({1'b0, radius});
      normal_y  <= -16'(ONE_Q14);
      tangent_x <= -17'sd256;
      tex_v     <= 17'd65536;
    end else begin
      pos_x     <= px_c;
      pos_y     <= py_q;
      pos_z     <= pz_c;
      normal_x  <= nx_q;
      normal_y  <= ny_q;
      normal_z  <= nz_q;
      tangent_x <= -pz_c;
      tangent_z <= px_c;
      tex_u     <= tex_u_d[TEX_DEPTH-1];
      tex_v     <= tex_v_d[TEX_DEPTH-1];
    end
  end

endmodule
